// ----- sv/turn_signal_flasher_unit_assert.svh -----
// Assertion macros for the verification of the flasher unit.
// Both macros expect clk_i, TSF_ASSERT also rst_ni, to be visible where used.
`ifndef TURN_SIGNAL_FLASHER_UNIT_ASSERT_SVH
`define TURN_SIGNAL_FLASHER_UNIT_ASSERT_SVH

// Property checked only outside of reset.
`define TSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define TSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- sv/tsf_pkg.sv -----
`default_nettype none

package tsf_pkg;

  localparam int unsigned CmdWidth    = 3;
  localparam int unsigned PeriodWidth = 16;

  localparam logic [PeriodWidth-1:0] PeriodReset = PeriodWidth'(50);

  localparam logic [CmdWidth-1:0] CMD_OFF         = 3'd0;
  localparam logic [CmdWidth-1:0] CMD_LEFT_ON     = 3'd1;
  localparam logic [CmdWidth-1:0] CMD_RIGHT_ON    = 3'd2;
  localparam logic [CmdWidth-1:0] CMD_BOTH_ON     = 3'd3;
  localparam logic [CmdWidth-1:0] CMD_LEFT_BLINK  = 3'd4;
  localparam logic [CmdWidth-1:0] CMD_RIGHT_BLINK = 3'd5;
  localparam logic [CmdWidth-1:0] CMD_BOTH_BLINK  = 3'd6;

  typedef struct packed {
    logic left;
    logic right;
  } tsf_lamps_t;

endpackage

`default_nettype wire

// ----- sv/tsf_in_stage.sv -----
`default_nettype none

module tsf_in_stage
  import tsf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CmdWidth-1:0] signal_command_i,
  input  logic                advance_i,
  output logic                valid_o,
  output logic [CmdWidth-1:0] cmd_o
);

  logic                valid_q;
  logic [CmdWidth-1:0] cmd_q;

  // The register frees up whenever its content moves on in the same cycle.
  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= signal_command_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule

`default_nettype wire

// ----- sv/tsf_core.sv -----
`default_nettype none

module tsf_core
  import tsf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [PeriodWidth-1:0] cfg_data_i,
  input  logic                   fire_i,
  input  logic [CmdWidth-1:0]    cmd_i,
  output tsf_lamps_t             lamps_o
);

  logic [PeriodWidth-1:0] period_q;
  logic [CmdWidth-1:0]    last_cmd_q, last_cmd_d;
  logic [PeriodWidth-1:0] count_q, count_d;
  logic                   left_phase_q, left_phase_d;
  logic                   right_phase_q, right_phase_d;
  logic                   both_phase_q, both_phase_d;
  tsf_lamps_t             level_q, level_d;

  logic [PeriodWidth-1:0] count_eff;
  logic                   apply;

  always_comb begin
    // A new command restarts the period, so it takes effect at once.
    count_eff     = (cmd_i != last_cmd_q) ? '0 : count_q;
    apply         = (count_eff == '0);
    left_phase_d  = left_phase_q;
    right_phase_d = right_phase_q;
    both_phase_d  = both_phase_q;
    level_d       = level_q;
    if (apply) begin
      case (cmd_i)
        CMD_OFF: begin
          level_d.left  = 1'b0;
          level_d.right = 1'b0;
        end
        CMD_LEFT_ON: begin
          level_d.left = 1'b1;
        end
        CMD_RIGHT_ON: begin
          level_d.right = 1'b1;
        end
        CMD_BOTH_ON: begin
          level_d.left  = 1'b1;
          level_d.right = 1'b1;
        end
        CMD_LEFT_BLINK: begin
          left_phase_d = !left_phase_q;
          level_d.left = !left_phase_q;
        end
        CMD_RIGHT_BLINK: begin
          right_phase_d = !right_phase_q;
          level_d.right = !right_phase_q;
        end
        CMD_BOTH_BLINK: begin
          both_phase_d  = !both_phase_q;
          level_d.left  = !both_phase_q;
          level_d.right = !both_phase_q;
        end
        default: begin
        end
      endcase
    end
    // A zero period reloads zero and wraps to all ones here.
    count_d    = (apply ? period_q : count_eff) - PeriodWidth'(1);
    last_cmd_d = cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q      <= PeriodReset;
      last_cmd_q    <= CMD_OFF;
      count_q       <= '0;
      left_phase_q  <= 1'b0;
      right_phase_q <= 1'b0;
      both_phase_q  <= 1'b0;
      level_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      if (fire_i) begin
        last_cmd_q    <= last_cmd_d;
        count_q       <= count_d;
        left_phase_q  <= left_phase_d;
        right_phase_q <= right_phase_d;
        both_phase_q  <= both_phase_d;
        level_q       <= level_d;
      end
    end
  end

  assign lamps_o = level_d;

endmodule

`default_nettype wire

// ----- sv/tsf_out_stage.sv -----
`default_nettype none

module tsf_out_stage
  import tsf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  tsf_lamps_t lamps_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic       advance_o,
  output logic       left_lamp_o,
  output logic       right_lamp_o
);

  logic       valid_q;
  tsf_lamps_t lamps_q;

  assign advance_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      lamps_q <= lamps_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign left_lamp_o  = lamps_q.left;
  assign right_lamp_o = lamps_q.right;

endmodule

`default_nettype wire

// ----- sv/turn_signal_flasher_unit.sv -----
// Turn-signal flasher. Each transfer on the input channel (in_valid_i /
// in_ready_o, payload signal_command_i) is one control tick carrying the
// current command. Each tick yields exactly one transfer on the output
// channel (out_valid_o / out_ready_i) with the left and right lamp levels
// after that tick. The blink period in ticks is set through the cfg_valid_i /
// cfg_ready_o channel with cfg_data_i; cfg_ready_o is always high, and the
// period should only be changed while no tick is in flight.
// A transferred tick is held in the input register; its result is computed
// combinationally and captured in the output register, from which it is
// taken. Throughput is one tick per clock cycle while the receiver takes
// each result: the per-tick logic is a short single pass between the input
// register and the output register. When the receiver stalls, the output
// register holds its result and the input register can still take one
// more tick; after that in_ready_o drops until the output is taken.
// Reset clears both pipeline valid flags, core lamps and blink phases to off,
// the last command to off, the period counter to zero and the period to 50.
`default_nettype none

module turn_signal_flasher_unit
  import tsf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CmdWidth-1:0]    signal_command_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   left_lamp_o,
  output logic                   right_lamp_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [PeriodWidth-1:0] cfg_data_i
);

  logic                stage_valid;
  logic [CmdWidth-1:0] stage_cmd;
  logic                advance;
  tsf_lamps_t          lamps;

  // The period register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  tsf_in_stage u_in_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .signal_command_i (signal_command_i),
    .advance_i        (advance),
    .valid_o          (stage_valid),
    .cmd_o            (stage_cmd)
  );

  // The tick state advances exactly when the registered tick moves into the
  // output register, which keeps the state in step with delivered results.
  tsf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .fire_i     (stage_valid && advance),
    .cmd_i      (stage_cmd),
    .lamps_o    (lamps)
  );

  tsf_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (stage_valid),
    .lamps_i      (lamps),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .advance_o    (advance),
    .left_lamp_o  (left_lamp_o),
    .right_lamp_o (right_lamp_o)
  );

endmodule

`default_nettype wire

// ----- sv/tsf_checker.sv -----
`default_nettype none
`include "turn_signal_flasher_unit_assert.svh"

module tsf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic left_lamp_o,
  input logic right_lamp_o
);

  logic       stall;
  logic [1:0] lamps_now;

  // A result waits in the output register while the receiver holds off.
  assign stall     = out_valid_o && !out_ready_i;
  assign lamps_now = {left_lamp_o, right_lamp_o};

  `TSF_ASSERT(a_out_valid_holds, stall |=> out_valid_o, "result dropped while stalled")
  `TSF_ASSERT(a_out_lamps_hold, stall |=> $stable(lamps_now), "lamps changed while stalled")
  `TSF_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "result valid during reset")
  `TSF_ASSERT(a_no_bubble_stall, !stall |-> in_ready_o, "input stalled with a free output")

endmodule

bind turn_signal_flasher_unit tsf_checker u_tsf_checker (.*);

`default_nettype wire
